// ----- design/ddo_pkg.sv -----
// shared types, constants and tables for the odometry block
package ddo_pkg;

    localparam int CordicSteps = 16;
    localparam int CordicIters = (CordicSteps > 24) ? 24 : CordicSteps;
    localparam int IterW       = 5;

    localparam logic signed [33:0] CordicStart = 34'sd652032874;
    localparam logic signed [33:0] AngleHalf   = 34'sh080000000;
    localparam logic signed [33:0] AngleQuart  = 34'sh040000000;

    localparam logic [15:0] LeftRadiusRst  = 16'd1229;
    localparam logic [15:0] RightRadiusRst = 16'd1229;
    localparam logic [15:0] StepTimeRst    = 16'd655;
    localparam logic [23:0] AngleGainRst   = 24'd116096;

    typedef enum logic [1:0] {
        REG_LEFT_RADIUS  = 2'd0,
        REG_RIGHT_RADIUS = 2'd1,
        REG_STEP_TIME    = 2'd2,
        REG_ANGLE_GAIN   = 2'd3
    } reg_index_t;

    // datapath commands from the controller
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_ARC_RS,
        OP_ARC_LT,
        OP_ARC_RT,
        OP_SUMS,
        OP_TURN,
        OP_MID,
        OP_CORDIC,
        OP_FLIP,
        OP_MUL_X,
        OP_MUL_Y,
        OP_UPDATE
    } dp_op_t;

    typedef struct packed {
        dp_op_t           op;
        logic [IterW-1:0] iter;
    } dp_cmd_t;

    function automatic logic signed [33:0] atan_lookup(input logic [IterW-1:0] i);
        logic signed [33:0] r;
        case (i)
            5'd0:  r = 34'sh020000000;
            5'd1:  r = 34'sh012E4051E;
            5'd2:  r = 34'sh009FB385B;
            5'd3:  r = 34'sh0051111D4;
            5'd4:  r = 34'sh0028B0D43;
            5'd5:  r = 34'sh00145D7E1;
            5'd6:  r = 34'sh000A2F61E;
            5'd7:  r = 34'sh000517C55;
            5'd8:  r = 34'sh00028BE53;
            5'd9:  r = 34'sh000145F2F;
            5'd10: r = 34'sh0000A2F98;
            5'd11: r = 34'sh0000517CC;
            5'd12: r = 34'sh000028BE6;
            5'd13: r = 34'sh0000145F3;
            5'd14: r = 34'sh00000A2FA;
            5'd15: r = 34'sh00000517D;
            5'd16: r = 34'sh0000028BE;
            5'd17: r = 34'sh00000145F;
            5'd18: r = 34'sh000000A30;
            5'd19: r = 34'sh000000518;
            5'd20: r = 34'sh00000028C;
            5'd21: r = 34'sh000000146;
            5'd22: r = 34'sh0000000A3;
            5'd23: r = 34'sh000000051;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ----- design/ddo_if.sv -----
// valid/ready channel interfaces for the odometry block
interface ddo_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] left_speed;
    logic signed [15:0] right_speed;
    modport source (output valid, left_speed, right_speed, input ready);
    modport sink (input valid, left_speed, right_speed, output ready);
endinterface

interface ddo_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [15:0]        heading;
    modport source (output valid, pos_x, pos_y, heading, input ready);
    modport sink (input valid, pos_x, pos_y, heading, output ready);
endinterface

// ----- design/ddo_ctrl.sv -----
// sequencer for the odometry datapath
module ddo_ctrl
    import ddo_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    output dp_cmd_t cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_ARC_RS, S_ARC_LT, S_ARC_RT, S_SUMS, S_TURN, S_MID,
        S_CORDIC, S_FLIP, S_MUL_X, S_MUL_Y, S_UPDATE
    } state_t;

    state_t           state_reg, state_next;
    logic [IterW-1:0] iter_reg, iter_next;
    logic             out_valid_reg, out_valid_next;

    // a new request may enter in idle once the previous result's slot frees
    assign in_ready  = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        iter_next      = iter_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd.op         = OP_NONE;
        cmd.iter       = iter_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_ARC_RS;
                end
            end
            S_ARC_RS: begin cmd.op = OP_ARC_RS; state_next = S_ARC_LT; end
            S_ARC_LT: begin cmd.op = OP_ARC_LT; state_next = S_ARC_RT; end
            S_ARC_RT: begin cmd.op = OP_ARC_RT; state_next = S_SUMS; end
            S_SUMS:   begin cmd.op = OP_SUMS;   state_next = S_TURN; end
            S_TURN:   begin cmd.op = OP_TURN;   state_next = S_MID; end
            S_MID:
            begin
                cmd.op     = OP_MID;
                iter_next  = '0;
                state_next = S_CORDIC;
            end
            S_CORDIC:
            begin
                cmd.op    = OP_CORDIC;
                iter_next = iter_reg + 1'b1;
                if (iter_reg == IterW'(CordicIters - 1))
                    state_next = S_FLIP;
            end
            S_FLIP:   begin cmd.op = OP_FLIP;  state_next = S_MUL_X; end
            S_MUL_X:  begin cmd.op = OP_MUL_X; state_next = S_MUL_Y; end
            S_MUL_Y:  begin cmd.op = OP_MUL_Y; state_next = S_UPDATE; end
            S_UPDATE:
            begin
                cmd.op         = OP_UPDATE;
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            iter_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            iter_reg      <= iter_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ----- design/ddo_datapath.sv -----
// arithmetic, cordic and pose state of the odometry block
module ddo_datapath
    import ddo_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  dp_cmd_t            cmd,
    input  logic signed [15:0] left_speed,
    input  logic signed [15:0] right_speed,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [23:0]        cfg_data,
    output logic signed [31:0] pos_x,
    output logic signed [31:0] pos_y,
    output logic [15:0]        heading
);

    logic [15:0] left_radius_reg, right_radius_reg, step_time_reg;
    logic [23:0] angle_gain_reg;

    logic signed [15:0] vl_reg, vr_reg;
    logic signed [32:0] prod_reg;      // speed * radius of the same wheel
    logic signed [49:0] arc_l_reg, arc_r_reg;
    logic signed [34:0] dist_reg;
    logic signed [34:0] diff_reg;
    logic signed [42:0] turn_reg;      // low 24 bits update the heading, bits 24:1 give the half turn
    logic signed [33:0] cx_reg, cy_reg, z_reg;
    logic               flip_reg;
    logic signed [68:0] mx_reg, my_reg;
    logic signed [31:0] x_reg, y_reg;
    logic [23:0]        head_reg;

    // shared multiplier, operands picked by the step (OP_ARC_LT also uses a second one)
    logic signed [34:0] ma;
    logic signed [33:0] mb;
    logic signed [68:0] mp;

    always_comb
    begin
        ma = '0;
        mb = '0;
        case (cmd.op)
            OP_ARC_RS: begin ma = 35'(vl_reg); mb = $signed({18'd0, left_radius_reg}); end
            OP_ARC_LT: begin ma = 35'(prod_reg); mb = $signed({18'd0, step_time_reg}); end
            OP_ARC_RT: begin ma = 35'(prod_reg); mb = $signed({18'd0, step_time_reg}); end
            OP_TURN:   begin ma = diff_reg; mb = $signed({10'd0, angle_gain_reg}); end
            OP_MUL_X:  begin ma = dist_reg; mb = cx_reg; end
            OP_MUL_Y:  begin ma = dist_reg; mb = cy_reg; end
            default:   begin ma = '0; mb = '0; end
        endcase
        mp = 69'(ma) * 69'(mb);
    end

    logic signed [50:0] arc_sum, arc_dif;
    logic [23:0]        mid;
    logic signed [33:0] z0;
    logic signed [33:0] sx, sy, at;
    logic signed [32:0] nx, ny;

    assign arc_sum = 51'(arc_l_reg) + 51'(arc_r_reg);
    assign arc_dif = 51'(arc_r_reg) - 51'(arc_l_reg);
    assign mid     = head_reg + turn_reg[24:1];
    assign z0      = $signed({{2{mid[23]}}, mid, 8'd0});
    assign sx      = cy_reg >>> cmd.iter;
    assign sy      = cx_reg >>> cmd.iter;
    assign at      = atan_lookup(cmd.iter);
    assign nx      = 33'(mx_reg >>> 38);
    assign ny      = 33'(my_reg >>> 38);

    function automatic logic signed [31:0] sat32(input logic signed [32:0] a,
                                                 input logic signed [32:0] b);
        logic signed [33:0] s;
        s = 34'(a) + 34'(b);
        if (s > 34'sh07FFFFFFF)
            return 32'sh7FFFFFFF;
        else if (s < -34'sh080000000)
            return 32'sh80000000;
        return s[31:0];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_radius_reg  <= LeftRadiusRst;
            right_radius_reg <= RightRadiusRst;
            step_time_reg    <= StepTimeRst;
            angle_gain_reg   <= AngleGainRst;
            x_reg            <= '0;
            y_reg            <= '0;
            head_reg         <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (reg_index_t'(cfg_index))
                    REG_LEFT_RADIUS:  left_radius_reg  <= cfg_data[15:0];
                    REG_RIGHT_RADIUS: right_radius_reg <= cfg_data[15:0];
                    REG_STEP_TIME:    step_time_reg    <= cfg_data[15:0];
                    REG_ANGLE_GAIN:   angle_gain_reg   <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.op == OP_UPDATE)
            begin
                x_reg    <= sat32(33'(x_reg), nx);
                y_reg    <= sat32(33'(y_reg), ny);
                head_reg <= head_reg + turn_reg[23:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                vl_reg <= left_speed;
                vr_reg <= right_speed;
            end
            OP_ARC_RS: prod_reg <= mp[32:0];
            OP_ARC_LT:
            begin
                arc_l_reg <= mp[49:0];
                prod_reg  <= 33'(vr_reg) * $signed({17'd0, right_radius_reg});
            end
            OP_ARC_RT: arc_r_reg <= mp[49:0];
            OP_SUMS:
            begin
                dist_reg <= 35'(arc_sum >>> 17);
                diff_reg <= 35'(arc_dif >>> 16);
            end
            OP_TURN: turn_reg <= 43'(mp >>> 16);
            OP_MID:
            begin
                cx_reg   <= CordicStart;
                cy_reg   <= '0;
                // fold into the right half-plane
                if (z0 > AngleQuart)
                begin
                    z_reg    <= z0 - AngleHalf;
                    flip_reg <= 1'b1;
                end
                else if (z0 < -AngleQuart)
                begin
                    z_reg    <= z0 + AngleHalf;
                    flip_reg <= 1'b1;
                end
                else
                begin
                    z_reg    <= z0;
                    flip_reg <= 1'b0;
                end
            end
            OP_CORDIC:
            begin
                if (!z_reg[33])
                begin
                    cx_reg <= cx_reg - sx;
                    cy_reg <= cy_reg + sy;
                    z_reg  <= z_reg - at;
                end
                else
                begin
                    cx_reg <= cx_reg + sx;
                    cy_reg <= cy_reg - sy;
                    z_reg  <= z_reg + at;
                end
            end
            OP_FLIP:
            begin
                if (flip_reg)
                begin
                    cx_reg <= -cx_reg;
                    cy_reg <= -cy_reg;
                end
            end
            OP_MUL_X: mx_reg <= mp;
            OP_MUL_Y: my_reg <= mp;
            default: ;
        endcase
    end

    assign pos_x   = x_reg;
    assign pos_y   = y_reg;
    assign heading = head_reg[23:8];

endmodule

// ----- design/differential_drive_odometry.sv -----
// top level of the differential-drive odometry block
// Wheel-speed requests come in on wheel (valid/ready); each gives exactly
// one pose on pose: x and y in signed Q23.8 cm, saturating, and the
// heading as a 16-bit binary angle that wraps.
// Registers are written through cfg_we/cfg_index/cfg_data, by the user
// only while idle; the block does not enforce this. 0 left radius,
// 1 right radius, 2 step time, 3 angle gain. Other indexes are ignored.
// Each accepted request runs through the arc, sum, turn, mid-angle,
// CORDIC, flip, multiply and update steps before its pose is valid; the
// CORDIC loop runs one step a cycle and most steps share a multiplier. One
// request is in work at a time; the next is taken in the same cycle as
// the pose leaves, or at once if the pose register is free.
// A stalled receiver holds the pose register and the next request waits.
// Reset restores the register defaults and clears position and heading.
module differential_drive_odometry
    import ddo_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    ddo_in_if.sink      wheel,
    ddo_out_if.source   pose,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data
);

    dp_cmd_t cmd;

    ddo_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (wheel.valid),
        .in_ready  (wheel.ready),
        .out_valid (pose.valid),
        .out_ready (pose.ready),
        .cmd       (cmd)
    );

    ddo_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .left_speed  (wheel.left_speed),
        .right_speed (wheel.right_speed),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .pos_x       (pose.pos_x),
        .pos_y       (pose.pos_y),
        .heading     (pose.heading)
    );

endmodule

// ----- dv/tb_differential_drive_odometry.sv -----
// testbench for the differential-drive odometry block: predictor, stimulus and checker
`timescale 1ns / 1ps

module tb_differential_drive_odometry;
    import ddo_pkg::*;

    typedef struct {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic [15:0]        heading;
    } pose_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [1:0] cfg_index = REG_LEFT_RADIUS;
    logic [23:0] cfg_data = '0;

    ddo_in_if  wheel ();
    ddo_out_if pose ();

    differential_drive_odometry DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .wheel     (wheel.sink),
        .pose      (pose.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    // predictor state and register copy
    logic [15:0] radius_l, radius_r, period;
    logic [23:0] gain;
    longint      est_x, est_y;
    logic [23:0] est_angle;

    pose_t  pending_poses[$];
    int     errors = 0;
    int     poses_seen = 0;
    int     sent = 0;
    longint cycles = 0;
    int     send_idle = 0;
    int     recv_stall = 0;
    bit     hold_off = 1'b0;

    localparam int Latency = 40;
    localparam longint CycleLimit = 3000000;

    function automatic longint floor_shift(longint v, int n);
        return v >>> n;
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint arctan_step(int i);
        longint t[24] = '{
            64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
            64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
            64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
            64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
            64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051};
        return t[i];
    endfunction

    task automatic rotate_to(input logic [23:0] ang, output longint c, output longint s);
        longint z, cx, cy, dx, dy;
        bit flip;
        int n;
        z = longint'($signed({ang, 8'h00}));
        flip = 1'b0;
        cx = 652032874;
        cy = 0;
        n = (CordicSteps > 24) ? 24 : CordicSteps;
        if (z > 64'sd1073741824)
        begin
            z -= 64'sd2147483648;
            flip = 1'b1;
        end
        else if (z < -64'sd1073741824)
        begin
            z += 64'sd2147483648;
            flip = 1'b1;
        end
        for (int i = 0; i < n; i++)
        begin
            dx = floor_shift(cy, i);
            dy = floor_shift(cx, i);
            if (z >= 0)
            begin
                cx -= dx;
                cy += dy;
                z -= arctan_step(i);
            end
            else
            begin
                cx += dx;
                cy -= dy;
                z += arctan_step(i);
            end
        end
        c = flip ? -cx : cx;
        s = flip ? -cy : cy;
    endtask

    task automatic advance_pose(input logic signed [15:0] vl, input logic signed [15:0] vr);
        longint arc_l, arc_r, travel, diff, turn, c, s;
        logic [23:0] mid;
        pose_t p;
        arc_l = longint'(vl) * longint'(radius_l) * longint'(period);
        arc_r = longint'(vr) * longint'(radius_r) * longint'(period);
        travel = floor_shift(arc_l + arc_r, 17);
        diff = floor_shift(arc_r - arc_l, 16);
        turn = floor_shift(diff * longint'(gain), 16);
        mid = est_angle + 24'(floor_shift(turn, 1));
        rotate_to(mid, c, s);
        est_x = clamp32(est_x + floor_shift(travel * c, 38));
        est_y = clamp32(est_y + floor_shift(travel * s, 38));
        est_angle = est_angle + 24'(turn);
        p.pos_x = 32'(est_x);
        p.pos_y = 32'(est_y);
        p.heading = est_angle[23:8];
        pending_poses.push_back(p);
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [23:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_LEFT_RADIUS:  radius_l = val[15:0];
            REG_RIGHT_RADIUS: radius_r = val[15:0];
            REG_STEP_TIME:    period = val[15:0];
            default:          gain = val;
        endcase
    endtask

    // valid stays high after an accept so back-to-back requests need no gap
    task automatic send_speeds(input logic signed [15:0] vl, input logic signed [15:0] vr);
        while (send_idle > 0 && $urandom_range(99, 0) < send_idle)
        begin
            wheel.valid <= 1'b0;
            @(posedge clk);
        end
        wheel.valid <= 1'b1;
        wheel.left_speed <= vl;
        wheel.right_speed <= vr;
        @(posedge clk);
        while (!wheel.ready)
            @(posedge clk);
        advance_pose(vl, vr);
        sent++;
    endtask

    task automatic wait_drained();
        wheel.valid <= 1'b0;
        while (pending_poses.size() != 0)
            @(posedge clk);
        repeat (Latency) @(posedge clk);
    endtask

    task automatic set_regs(input logic [15:0] rl, input logic [15:0] rr,
                            input logic [15:0] st, input logic [23:0] ag);
        wait_drained();
        write_reg(REG_LEFT_RADIUS, rl);
        write_reg(REG_RIGHT_RADIUS, rr);
        write_reg(REG_STEP_TIME, st);
        write_reg(REG_ANGLE_GAIN, ag);
    endtask

    task automatic random_speeds(input int n);
        logic signed [15:0] a, b;
        for (int k = 0; k < n; k++)
        begin
            case ($urandom_range(3, 0))
                0: begin a = 16'($urandom); b = 16'($urandom); end
                1: begin a = 16'($urandom); b = a; end
                2: begin a = 16'($signed($urandom_range(800, 0)) - 400); b = a + 16'($urandom_range(60, 0)); end
                default: begin a = $urandom_range(1) ? 16'sh7FFF : 16'sh8000; b = 16'($urandom); end
            endcase
            send_speeds(a, b);
        end
    endtask

    task automatic test_directed();
        send_speeds(16'sd0, 16'sd0);
        send_speeds(16'sh7FFF, 16'sh7FFF);
        send_speeds(16'sh8000, 16'sh8000);
        send_speeds(16'sh7FFF, 16'sh8000);
        send_speeds(16'sh8000, 16'sh7FFF);
        send_speeds(16'sd256, 16'sd512);
        send_speeds(-16'sd256, 16'sd256);
        send_speeds(16'shFFFF, 16'sd1);
        send_speeds(16'sh5555, 16'shAAAA);
        send_speeds(16'shAAAA, 16'sh5555);
    endtask

    // large values drive position into saturation and spin heading round
    task automatic test_saturation();
        set_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 24'hFFFFFF);
        for (int k = 0; k < 6; k++)
            send_speeds(16'sh7FFF, 16'sh7FFF);
        for (int k = 0; k < 6; k++)
            send_speeds(16'sh8000, 16'sh8000);
        send_speeds(16'sh8000, 16'sh7FFF);
        set_regs(16'h0000, 16'h0000, 16'h0000, 24'h000000);
        send_speeds(16'sh7FFF, 16'sh8000);
        random_speeds(4);
    endtask

    task automatic test_random_phases();
        int modes[4] = '{0, 77, 0, 19};
        int stalls[4] = '{0, 0, 77, 19};
        for (int ph = 0; ph < 8; ph++)
        begin
            set_regs(16'($urandom), 16'($urandom), 16'($urandom_range(2000, 0)),
                     24'($urandom));
            send_idle = modes[ph % 4];
            recv_stall = stalls[ph % 4];
            random_speeds(185);
        end
        send_idle = 0;
        recv_stall = 0;
    endtask

    task automatic test_back_pressure();
        wait_drained();
        write_reg(REG_ANGLE_GAIN, AngleGainRst);
        hold_off = 1'b1;
        random_speeds(10);
        // pause the sender until everything is out
        wait_drained();
        random_speeds(5);
    endtask

    // receiver: random stalls plus one long hold-off
    initial
    begin
        pose.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                pose.ready <= 1'b0;
                repeat (400) @(posedge clk);
                hold_off = 1'b0;
            end
            pose.ready <= !(recv_stall > 0 && $urandom_range(99, 0) < recv_stall);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CycleLimit)
        begin
            $display("Verification failed");
            $finish;
        end
        if (rst_n && pose.valid && pose.ready)
        begin
            if (pending_poses.size() == 0)
            begin
                $error("pose with no request outstanding");
                errors++;
            end
            else
            begin
                pose_t e;
                e = pending_poses.pop_front();
                poses_seen++;
                if (pose.pos_x !== e.pos_x)
                begin
                    $error("pos_x expected %0d got %0d", e.pos_x, pose.pos_x);
                    errors++;
                end
                if (pose.pos_y !== e.pos_y)
                begin
                    $error("pos_y expected %0d got %0d", e.pos_y, pose.pos_y);
                    errors++;
                end
                if (pose.heading !== e.heading)
                begin
                    $error("heading expected %0d got %0d", e.heading, pose.heading);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        wheel.valid = 1'b0;
        wheel.left_speed = '0;
        wheel.right_speed = '0;
        radius_l = LeftRadiusRst;
        radius_r = RightRadiusRst;
        period = StepTimeRst;
        gain = AngleGainRst;
        est_x = 0;
        est_y = 0;
        est_angle = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_saturation();
        test_random_phases();
        test_back_pressure();
        wait_drained();
        $display("covered %0d wheel requests, %0d poses checked, over register extremes",
                 sent, poses_seen);
        $display("and idle, stall and long hold-off phases");
        if (errors == 0 && pending_poses.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
